// ===== design/stereo_moving_average_filter_assert.svh =====
// Assertion macros for the stereo moving-average filter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef STEREO_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define STEREO_MOVING_AVERAGE_FILTER_ASSERT_SVH

// Check while out of reset.
`define SMAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define SMAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/smaf_pkg.sv =====
// Shared types and constants for the stereo moving-average filter.
// No dependencies.
package smaf_pkg;

  localparam int DEF_MAX_TAPS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int WIN_W        = 4;
  localparam int PHASE_W      = 3;

  localparam logic [PHASE_W-1:0] PHASE_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_DONE = 3'd4;

  typedef struct packed {
    logic                       avg;
    logic                       neg;
    logic [SAMPLE_W-1:0]        quot;
    logic signed [SAMPLE_W-1:0] cur;
  } lane_res_t;

endpackage

// ===== design/stereo_moving_average_filter.sv =====
// Stereo moving-average filter, one left/right sample pair per transaction.
// Each transaction passes through the lane pipeline (window sum,
// magnitude, reciprocal multiply, quotient correction) and the next pair is
// accepted on the cycle its predecessor moves into the output register, so
// only one pair is in the lane pipeline at a time. Both channels run in
// parallel lanes. Write window_len through cfg_we/cfg_wdata only while idle;
// values above MAX_TAPS act as MAX_TAPS.
// Depends on smaf_pkg, smaf_lane, smaf_merge and the assertion header.
`include "stereo_moving_average_filter_assert.svh"

module stereo_moving_average_filter #(
  parameter int MAX_TAPS = smaf_pkg::DEF_MAX_TAPS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [smaf_pkg::WIN_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                                 in_buffer_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [smaf_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [smaf_pkg::SAMPLE_W-1:0] out_right_out
);
  import smaf_pkg::*;

  localparam int FILL_W = $clog2(MAX_TAPS);

  logic [WIN_W-1:0]   win_r;
  logic [WIN_W-1:0]   win_sat;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_eff;
  logic [FILL_W-1:0]  fill_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic               avg;
  logic               accept;
  logic               merge_free;
  logic               merge_load;
  lane_res_t          left_res;
  lane_res_t          right_res;

  assign win_sat  = (int'(win_r) > MAX_TAPS) ? WIN_W'(MAX_TAPS) : win_r;
  assign fill_eff = in_buffer_start ? '0 : fill_r;
  assign avg      = (int'(win_sat) >= 2) && (int'(fill_eff) >= int'(win_sat) - 1);
  assign fill_nxt = (int'(fill_eff) < MAX_TAPS - 1) ? fill_eff + 1'b1 : fill_eff;

  assign merge_load = (phase_r == PHASE_DONE) && merge_free;
  assign in_stall   = !((phase_r == PHASE_IDLE) || merge_load);
  assign accept     = in_valid && !in_stall;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = PHASE_IDLE + 1'b1;
    end else if (merge_load) begin
      phase_nxt = PHASE_IDLE;
    end else if (phase_r != PHASE_IDLE && phase_r != PHASE_DONE) begin
      phase_nxt = phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      phase_r <= PHASE_IDLE;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r <= fill_nxt;
      end
      phase_r <= phase_nxt;
    end
  end

  smaf_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_left (
    .clk       (clk),
    .load      (accept),
    .win       (win_sat),
    .avg_in    (avg),
    .sample_in (in_left_sample),
    .res       (left_res)
  );

  smaf_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_right (
    .clk       (clk),
    .load      (accept),
    .win       (win_sat),
    .avg_in    (avg),
    .sample_in (in_right_sample),
    .res       (right_res)
  );

  smaf_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (merge_load),
    .left_res      (left_res),
    .right_res     (right_res),
    .free          (merge_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

  `SMAF_ASSERT(a_accept_starts, accept |=> phase_r == PHASE_IDLE + 1'b1, "pipeline did not start")
  `SMAF_ASSERT(a_phase_advance, (phase_r != PHASE_IDLE && phase_r != PHASE_DONE) |=> phase_r == $past(phase_r) + 1'b1, "pipeline did not advance")
  `SMAF_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(phase_r) == PHASE_DONE, "result without finished pipeline")
  `SMAF_ASSERT_ALWAYS(a_fill_bound, int'(fill_r) <= MAX_TAPS - 1, "fill count past history depth")

endmodule

// ===== design/smaf_lane.sv =====
// One channel lane: delay line, window sum and divide by the window length.
// Depends on smaf_pkg.
module smaf_lane #(
  parameter int MAX_TAPS = 8
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic [smaf_pkg::WIN_W-1:0]           win,
  input  logic                                 avg_in,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] sample_in,
  output smaf_pkg::lane_res_t                  res
);
  import smaf_pkg::*;

  localparam int HIST  = MAX_TAPS - 1;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_TAPS);
  localparam int MAG_W = SUM_W;
  localparam int NWIN  = 2 ** WIN_W;

  logic signed [SAMPLE_W-1:0] hist_r [HIST];
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic                       avg_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic [2*MAG_W-1:0]         prod_r;
  logic [SAMPLE_W-1:0]        quot_r;
  logic [MAG_W-1:0]           recip_tab [NWIN];
  logic [MAG_W-1:0]           q0;
  logic [MAG_W+WIN_W-1:0]     qw;
  logic [MAG_W+WIN_W-1:0]     rem;
  logic [MAG_W-1:0]           q1;

  for (genvar g = 0; g < NWIN; g++) begin : g_recip
    if (g >= 2) begin : g_div
      localparam longint RECIP = (64'd1 << MAG_W) / g;
      assign recip_tab[g] = MAG_W'(RECIP);
    end else begin : g_none
      assign recip_tab[g] = '0;
    end
  end

  always_comb begin
    sum_nxt = SUM_W'(sample_in);
    for (int k = 0; k < HIST; k++) begin
      if (k < int'(win) - 1) begin
        sum_nxt = sum_nxt + SUM_W'(hist_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = HIST - 1; k > 0; k--) begin
        hist_r[k] <= hist_r[k-1];
      end
      hist_r[0] <= sample_in;
      sum_r     <= sum_nxt;
      cur_r     <= sample_in;
      avg_r     <= avg_in;
    end
  end

  always_comb begin
    q0  = prod_r[2*MAG_W-1:MAG_W];
    qw  = q0 * win;
    rem = {{WIN_W{1'b0}}, mag_r} - qw;
    q1  = (rem >= (MAG_W+WIN_W)'(win)) ? q0 + 1'b1 : q0;
  end

  always_ff @(posedge clk) begin
    neg_r  <= sum_r[SUM_W-1];
    mag_r  <= sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
    prod_r <= mag_r * recip_tab[win];
    quot_r <= q1[SAMPLE_W-1:0];
  end

  assign res.avg  = avg_r;
  assign res.neg  = neg_r;
  assign res.quot = quot_r;
  assign res.cur  = cur_r;

endmodule

// ===== design/smaf_merge.sv =====
// Merge stage: applies sign or passthrough for both lanes into the output register.
// Depends on smaf_pkg.
module smaf_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  smaf_pkg::lane_res_t                   left_res,
  input  smaf_pkg::lane_res_t                   right_res,
  output logic                                  free,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [smaf_pkg::SAMPLE_W-1:0]  out_left_out,
  output logic signed [smaf_pkg::SAMPLE_W-1:0]  out_right_out
);
  import smaf_pkg::*;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic signed [SAMPLE_W-1:0] left_nxt;
  logic signed [SAMPLE_W-1:0] right_nxt;

  function automatic logic signed [SAMPLE_W-1:0] finish(lane_res_t r);
    logic [SAMPLE_W-1:0] q;
    q = r.neg ? -r.quot : r.quot;
    return r.avg ? signed'(q) : r.cur;
  endfunction

  assign free      = !out_valid_r || !out_stall;
  assign left_nxt  = finish(left_res);
  assign right_nxt = finish(right_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = left_r;
  assign out_right_out = right_r;

endmodule

// ===== tb/smaf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the stereo moving-average filter: tracks the window register,
// predicts every accepted input pair and compares the outputs in order.
// Depends on smaf_pkg for widths and the tap count.
module smaf_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [smaf_pkg::WIN_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                                 in_buffer_start,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] out_left_out,
  input  logic signed [smaf_pkg::SAMPLE_W-1:0] out_right_out,
  output int                                   err_count,
  output int                                   pending,
  output int                                   checked
);

  localparam int TAPS = smaf_pkg::DEF_MAX_TAPS;
  localparam int HIST = TAPS - 1;

  typedef logic signed [smaf_pkg::SAMPLE_W-1:0] sample_t;
  typedef struct packed {
    sample_t lsamp;
    sample_t rsamp;
  } stereo_t;

  stereo_t                    expected_pairs[$];
  sample_t                    hist_l[HIST];
  sample_t                    hist_r[HIST];
  int                         fill;
  logic [smaf_pkg::WIN_W-1:0] win_reg;

  initial begin
    err_count = 0;
    pending   = 0;
    checked   = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  function automatic stereo_t average_pair(stereo_t x, logic bs);
    int      w;
    int      k;
    int      sum_l;
    int      sum_r;
    stereo_t y;
    w = (win_reg > TAPS) ? TAPS : int'(win_reg);
    if (bs) fill = 0;
    y = x;
    if (w >= 2 && fill >= w - 1) begin
      sum_l = x.lsamp;
      sum_r = x.rsamp;
      for (k = 0; k < w - 1; k++) begin
        sum_l += hist_l[k];
        sum_r += hist_r[k];
      end
      y.lsamp = sample_t'(sum_l / w);
      y.rsamp = sample_t'(sum_r / w);
    end
    for (k = HIST - 1; k > 0; k--) begin
      hist_l[k] = hist_l[k-1];
      hist_r[k] = hist_r[k-1];
    end
    hist_l[0] = x.lsamp;
    hist_r[0] = x.rsamp;
    if (fill < HIST) fill++;
    return y;
  endfunction

  always @(posedge clk) begin : scoreboard
    stereo_t got;
    stereo_t want;
    stereo_t arrived;
    int      k;
    if (!rst_n) begin
      expected_pairs.delete();
      for (k = 0; k < HIST; k++) begin
        hist_l[k] = '0;
        hist_r[k] = '0;
      end
      fill    = 0;
      win_reg = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got.lsamp = out_left_out;
        got.rsamp = out_right_out;
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("unexpected output pair %0d/%0d", got.lsamp, got.rsamp));
        end else begin
          want = expected_pairs.pop_front();
          checked++;
          if (got.lsamp !== want.lsamp)
            report_mismatch($sformatf("left_out got %0d expected %0d", got.lsamp, want.lsamp));
          if (got.rsamp !== want.rsamp)
            report_mismatch($sformatf("right_out got %0d expected %0d", got.rsamp, want.rsamp));
        end
      end
      if (in_valid && !in_stall) begin
        arrived.lsamp = in_left_sample;
        arrived.rsamp = in_right_sample;
        expected_pairs.push_back(average_pair(arrived, in_buffer_start));
      end
      if (cfg_we) win_reg = cfg_wdata;
    end
    pending = expected_pairs.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the stereo moving-average filter testbench: clock, reset, stimulus,
// output back-pressure, watchdog and verdict. Depends on smaf_pkg,
// smaf_checker and the filter RTL.
module tb;

  localparam int TAIL_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 36;

  typedef logic signed [smaf_pkg::SAMPLE_W-1:0] sample_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [smaf_pkg::WIN_W-1:0] cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  sample_t                    in_left_sample;
  sample_t                    in_right_sample;
  logic                       in_buffer_start;
  logic                       out_valid;
  logic                       out_stall;
  sample_t                    out_left_out;
  sample_t                    out_right_out;

  int err_count;
  int pending;
  int checked;
  int tx_max_gap = 0;
  int rx_max_gap = 0;
  int long_hold  = 0;
  int sent       = 0;
  int settings   = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  stereo_moving_average_filter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_buffer_start (in_buffer_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out)
  );

  smaf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_buffer_start (in_buffer_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .err_count       (err_count),
    .pending         (pending),
    .checked         (checked)
  );

  // output back-pressure, one draw per result transaction
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = $urandom_range(0, rx_max_gap);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: begin
        v = $urandom_range(0, 16);
        return sample_t'(v - 8);
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 14;
    endcase
  endfunction

  task automatic send_pair(sample_t l, sample_t r, logic bs);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_buffer_start <= bs;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(logic [smaf_pkg::WIN_W-1:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [smaf_pkg::WIN_W-1:0] w;
    int                         run_left;
    logic                       bs;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_left_sample  = '0;
    in_right_sample = '0;
    in_buffer_start = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // window zero out of reset: pass-through
    tx_max_gap = 3;
    rx_max_gap = 3;
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b0);
    send_pair(16'sh0000, -16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sh0000, 1'b0);

    // window two: buffer start passes through, negative sums truncate toward zero
    set_window(4'd2);
    send_pair(16'sd5, -16'sd5, 1'b1);
    send_pair(-16'sd8, 16'sd8, 1'b0);
    send_pair(-16'sd3, 16'sd3, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);

    // full window of extremes
    set_window(4'd8);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    repeat (7) send_pair(16'sh8000, 16'sh7FFF, 1'b0);
    send_pair(-16'sd32767, 16'sd32766, 1'b0);

    // window above the tap count saturates
    set_window(4'd15);
    send_pair(-16'sd3, 16'sd3, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(16'sd2, -16'sd2, 1'b0);

    // window change mid-buffer uses the history already held
    set_window(4'd1);
    send_pair(16'sd100, -16'sd100, 1'b1);
    send_pair(16'sd7, -16'sd7, 1'b0);
    set_window(4'd3);
    send_pair(16'sd1, -16'sd2, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       w = 4'd8;
        1:       w = 4'd0;
        2:       w = 4'd15;
        3:       w = 4'd1;
        4:       w = 4'd2;
        default: w = 4'($urandom_range(0, 15));
      endcase
      set_window(w);
      tx_max_gap = pick_gap();
      rx_max_gap = pick_gap();
      if (p == 5) tx_max_gap = 0;
      run_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == 8) long_hold = LONG_HOLD;
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          bs = (i > 0) || ($urandom_range(0, 4) != 0);
        end else begin
          bs = ($urandom_range(0, 19) == 0);
        end
        run_left--;
        send_pair(pick_sample(), pick_sample(), bs);
      end
    end

    drain();
    $display("Covered %0d stereo pairs over %0d window writes, %0d output pairs compared,",
             sent, settings, checked);
    $display("including saturated, pass-through and mid-buffer window changes under back-pressure.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
